/* sv/tclt_pkg.sv */
// ----------------------------------------------------------------------------
// tclt_pkg: shared types, constants and step functions
// Fixed-point constants, CORDIC and square-root step helpers for the
// two-crank linkage tracer.
// ----------------------------------------------------------------------------
package tclt_pkg;

	// defaults for the top-level parameters
	localparam int FRAC_BITS_DEF = 10;
	localparam int ANGLE_ITER_DEF = 16;
	localparam int ANGLE_ITER_MAX = 24;
	localparam int WORK_BITS = 20;

	// configuration register indexes
	localparam logic [2:0] REG_C1_CENTER = 3'd0;
	localparam logic [2:0] REG_C2_CENTER = 3'd1;
	localparam logic [2:0] REG_C1_RADIUS = 3'd2;
	localparam logic [2:0] REG_C2_RADIUS = 3'd3;
	localparam logic [2:0] REG_C1_MOTION = 3'd4;
	localparam logic [2:0] REG_C2_MOTION = 3'd5;
	localparam logic [2:0] REG_COUPLER = 3'd6;
	localparam logic [2:0] REG_TRACER = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OPEN = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_COIN = 2'd3;

	// angle constants, radians Q.30
	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic [35:0] DEG_Q30 = 36'd18740330;
	localparam logic signed [39:0] GAIN_Q20 = 40'sd636751;
	// ceil(2^32 / 360): exact floor division for values below 2^24
	localparam logic [23:0] RECIP_360 = 24'd11930465;
	localparam logic [23:0] DEG_FULL = 24'd360;
	localparam logic signed [39:0] OUT_MAX = 40'sd524287;
	localparam logic signed [39:0] OUT_MIN = -40'sd524288;

	typedef struct packed {
		logic signed [39:0] x;
		logic signed [39:0] y;
		logic signed [35:0] z;
	} cord_t;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] res;
	} sq_t;

	typedef struct packed {
		logic signed [35:0] th;
		logic neg;
	} fold_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [20:0] quot;
		logic [40:0] den;
		logic neg;
	} dv_t;

	// payload carried alongside the working datapath
	typedef struct packed {
		logic signed [31:0] p1x;
		logic signed [31:0] p1y;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [35:0] phi;
		logic signed [21:0] v;
		logic [1:0] status;
	} keep_t;

	// arctangent of 2^-k, Q.30
	function automatic logic signed [35:0] atan_q30(int k);
		logic signed [35:0] r;
		unique case (k)
			0: r = 36'sd843314856;
			1: r = 36'sd497837829;
			2: r = 36'sd263043836;
			3: r = 36'sd133525158;
			4: r = 36'sd67021686;
			5: r = 36'sd33543515;
			6: r = 36'sd16775850;
			7: r = 36'sd8388437;
			8: r = 36'sd4194282;
			9: r = 36'sd2097149;
			10: r = 36'sd1048575;
			11: r = 36'sd524287;
			12: r = 36'sd262143;
			13: r = 36'sd131071;
			14: r = 36'sd65535;
			15: r = 36'sd32767;
			16: r = 36'sd16383;
			17: r = 36'sd8191;
			18: r = 36'sd4095;
			19: r = 36'sd2047;
			20: r = 36'sd1023;
			21: r = 36'sd511;
			22: r = 36'sd255;
			23: r = 36'sd127;
			default: r = 36'sd0;
		endcase
		return r;
	endfunction

	// one rotation-mode CORDIC iteration
	function automatic cord_t rot_step(cord_t c, int k);
		cord_t r;
		if (c.z >= 0) begin
			r.x = c.x - (c.y >>> k);
			r.y = c.y + (c.x >>> k);
			r.z = c.z - atan_q30(k);
		end else begin
			r.x = c.x + (c.y >>> k);
			r.y = c.y - (c.x >>> k);
			r.z = c.z + atan_q30(k);
		end
		return r;
	endfunction

	// one vectoring-mode CORDIC iteration
	function automatic cord_t vec_step(cord_t c, int k);
		cord_t r;
		if (c.y >= 0) begin
			r.x = c.x + (c.y >>> k);
			r.y = c.y - (c.x >>> k);
			r.z = c.z + atan_q30(k);
		end else begin
			r.x = c.x - (c.y >>> k);
			r.y = c.y + (c.x >>> k);
			r.z = c.z - atan_q30(k);
		end
		return r;
	endfunction

	// bring an angle into -pi/2..pi/2, flag a half-turn
	function automatic fold_t fold_angle(logic signed [35:0] th);
		fold_t f;
		logic signed [35:0] t;
		t = th;
		if (t > PI_Q30) t = t - TWO_PI_Q30;
		if (t < -PI_Q30) t = t + TWO_PI_Q30;
		f.neg = 1'b0;
		if (t > HALF_PI_Q30) begin
			t = t - PI_Q30;
			f.neg = 1'b1;
		end else if (t < -HALF_PI_Q30) begin
			t = t + PI_Q30;
			f.neg = 1'b1;
		end
		f.th = t;
		return f;
	endfunction

	// one result bit of the integer square root, trial bit 4^j
	function automatic sq_t sq_step(sq_t s, int j);
		sq_t r;
		logic [63:0] bit_v;
		logic [63:0] trial;
		bit_v = 64'd1 << (2 * j);
		trial = s.res + bit_v;
		if (s.n >= trial) begin
			r.n = s.n - trial;
			r.res = (s.res >> 1) + bit_v;
		end else begin
			r.n = s.n;
			r.res = s.res >> 1;
		end
		return r;
	endfunction

endpackage

/* sv/two_crank_linkage_tracer_core.sv */
// ----------------------------------------------------------------------------
// two_crank_linkage_tracer_core: five-bar linkage tracer point
// Throughput: one frame index per cycle; busy stays low, the pipeline never
// stalls and the receiver takes each result in its done cycle.
// Depth is set by four CORDIC chains, a 32-step and a 21-step square root
// and a 21-step divider, one step per stage.
// Reset: arst_n clears the valid chain and loads register reset values.
// ----------------------------------------------------------------------------
module two_crank_linkage_tracer_core import tclt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_wdata,
	input  logic                start,
	output logic                busy,
	input  logic [15:0]         frame_index,
	output logic                done,
	output logic signed [19:0]  end_x,
	output logic signed [19:0]  end_y,
	output logic [1:0]          status
);

	localparam int N = ANGLE_ITERATIONS;
	localparam int LAT = 95 + 4 * N;
	localparam int SH = (WORK_BITS - FRAC_BITS < 1) ? 1 : WORK_BITS - FRAC_BITS;

	// configuration registers
	logic [15:0] c1_center_q, c2_center_q, tracer_q;
	logic [7:0]  c1_radius_q, c2_radius_q, coupler_q;
	logic [16:0] c1_motion_q, c2_motion_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_center_q <= 16'd0;
			c2_center_q <= 16'd0;
			c1_radius_q <= 8'd1;
			c2_radius_q <= 8'd1;
			c1_motion_q <= 17'd256;
			c2_motion_q <= 17'd2;
			coupler_q   <= 8'd30;
			tracer_q    <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_C1_CENTER: c1_center_q <= cfg_wdata[15:0];
				REG_C2_CENTER: c2_center_q <= cfg_wdata[15:0];
				REG_C1_RADIUS: c1_radius_q <= cfg_wdata[7:0];
				REG_C2_RADIUS: c2_radius_q <= cfg_wdata[7:0];
				REG_C1_MOTION: c1_motion_q <= cfg_wdata;
				REG_C2_MOTION: c2_motion_q <= cfg_wdata;
				REG_COUPLER:   coupler_q   <= cfg_wdata[7:0];
				REG_TRACER:    tracer_q    <= cfg_wdata[15:0];
			endcase
		end
	end

	// per-crank views of the registers
	logic signed [7:0] spd [0:1];
	logic [7:0] spd_mag [0:1];
	logic [8:0] ini [0:1];
	logic [7:0] rad [0:1];
	logic signed [7:0] ctr_x [0:1];
	logic signed [7:0] ctr_y [0:1];

	always_comb begin
		spd[0] = signed'(c1_motion_q[7:0]);
		spd[1] = signed'(c2_motion_q[7:0]);
		ini[0] = c1_motion_q[16:8];
		ini[1] = c2_motion_q[16:8];
		rad[0] = c1_radius_q;
		rad[1] = c2_radius_q;
		ctr_x[0] = signed'(c1_center_q[7:0]);
		ctr_y[0] = signed'(c1_center_q[15:8]);
		ctr_x[1] = signed'(c2_center_q[7:0]);
		ctr_y[1] = signed'(c2_center_q[15:8]);
		for (int w = 0; w < 2; w++) begin
			spd_mag[w] = spd[w][7] ? 8'(-spd[w]) : 8'(spd[w]);
		end
	end

	// the block always takes a beat
	assign busy = 1'b0;

	// valid chain, one bit per stage
	logic [LAT:1] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-1:1], start & ~busy};
		end
	end
	assign done = vld_s[LAT];

	// crank angle: ini + frame*|speed|, reduced mod 360, then to radians
	logic [23:0] ang_prod_s1 [0:1];
	logic [23:0] ang_n_s2 [0:1];
	logic [23:0] ang_n_s3 [0:1];
	logic [47:0] ang_qm_s3 [0:1];
	logic [8:0]  ang_deg_s4 [0:1];
	logic signed [35:0] ang_th_s5 [0:1];

	always_ff @(posedge clk) begin
		for (int w = 0; w < 2; w++) begin
			ang_prod_s1[w] <= 24'(frame_index) * 24'(spd_mag[w]);
			ang_n_s2[w]    <= ang_prod_s1[w] + 24'(ini[w]);
			ang_n_s3[w]    <= ang_n_s2[w];
			ang_qm_s3[w]   <= 48'(ang_n_s2[w]) * 48'(RECIP_360);
			ang_deg_s4[w]  <= 9'(ang_n_s3[w] - 24'(ang_qm_s3[w][47:32]) * DEG_FULL);
			ang_th_s5[w]   <= signed'(36'(ang_deg_s4[w]) * DEG_Q30);
		end
	end

	// crank sine/cosine CORDIC
	cord_t crk_s [0:1][0:N];
	logic  crk_neg_s [0:1][0:N];

	for (genvar w = 0; w < 2; w++) begin : g_crank
		fold_t crk_f;
		assign crk_f = fold_angle(ang_th_s5[w]);

		always_ff @(posedge clk) begin
			crk_s[w][0].x   <= GAIN_Q20;
			crk_s[w][0].y   <= 40'sd0;
			crk_s[w][0].z   <= crk_f.th;
			crk_neg_s[w][0] <= crk_f.neg;
		end

		for (genvar k = 0; k < N; k++) begin : g_crk
			always_ff @(posedge clk) begin
				crk_s[w][k+1]     <= rot_step(crk_s[w][k], k);
				crk_neg_s[w][k+1] <= crk_neg_s[w][k];
			end
		end
	end

	// crank pins in Q.20
	logic signed [31:0] pin_x_s [0:1];
	logic signed [31:0] pin_y_s [0:1];
	logic signed [23:0] crk_c [0:1];
	logic signed [23:0] crk_sn [0:1];

	always_comb begin
		for (int w = 0; w < 2; w++) begin
			crk_c[w]  = crk_neg_s[w][N] ? 24'(-crk_s[w][N].x) : 24'(crk_s[w][N].x);
			crk_sn[w] = crk_neg_s[w][N] ? 24'(-crk_s[w][N].y) : 24'(crk_s[w][N].y);
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < 2; w++) begin
			pin_x_s[w] <= (32'(ctr_x[w]) <<< WORK_BITS)
				+ 32'(signed'({1'b0, rad[w]})) * 32'(crk_c[w]);
			pin_y_s[w] <= (32'(ctr_y[w]) <<< WORK_BITS)
				+ 32'(signed'({1'b0, rad[w]})) * 32'(crk_sn[w]);
		end
	end

	// pin-to-pin vector, coincidence check
	keep_t dk_s;
	always_ff @(posedge clk) begin
		dk_s.p1x <= pin_x_s[0];
		dk_s.p1y <= pin_y_s[0];
		dk_s.dx  <= pin_x_s[1] - pin_x_s[0];
		dk_s.dy  <= pin_y_s[1] - pin_y_s[0];
		dk_s.phi <= 36'sd0;
		dk_s.v   <= 22'sd0;
		dk_s.status <= (pin_x_s[1] == pin_x_s[0] && pin_y_s[1] == pin_y_s[0])
			? ST_COIN : ST_OK;
	end

	// direction phi = atan2(dy, dx)
	cord_t v1_s [0:N];
	keep_t v1_k [0:N];

	always_ff @(posedge clk) begin
		v1_k[0] <= dk_s;
		if (dk_s.dx < 0) begin
			v1_s[0].x <= -40'(dk_s.dx);
			v1_s[0].y <= -40'(dk_s.dy);
			v1_s[0].z <= (dk_s.dy >= 0) ? PI_Q30 : -PI_Q30;
		end else begin
			v1_s[0].x <= 40'(dk_s.dx);
			v1_s[0].y <= 40'(dk_s.dy);
			v1_s[0].z <= 36'sd0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_v1
		always_ff @(posedge clk) begin
			v1_s[k+1] <= vec_step(v1_s[k], k);
			v1_k[k+1] <= v1_k[k];
		end
	end

	// squared pin distance
	logic [63:0] sq_xx_s, sq_yy_s;
	keep_t sq_k_s;
	keep_t sq_k_d;

	always_comb begin
		sq_k_d     = v1_k[N];
		sq_k_d.phi = v1_s[N].z;
	end

	always_ff @(posedge clk) begin
		sq_xx_s <= unsigned'(64'(v1_k[N].dx) * 64'(v1_k[N].dx));
		sq_yy_s <= unsigned'(64'(v1_k[N].dy) * 64'(v1_k[N].dy));
		sq_k_s  <= sq_k_d;
	end

	// b = floor(sqrt(dx^2 + dy^2))
	sq_t   rt1_s [0:32];
	keep_t rt1_k [0:32];

	always_ff @(posedge clk) begin
		rt1_s[0].n   <= sq_xx_s + sq_yy_s;
		rt1_s[0].res <= 64'd0;
		rt1_k[0]     <= sq_k_s;
	end

	for (genvar k = 0; k < 32; k++) begin : g_rt1
		always_ff @(posedge clk) begin
			rt1_s[k+1] <= sq_step(rt1_s[k], 31 - k);
			rt1_k[k+1] <= rt1_k[k];
		end
	end

	// law of cosines terms and closure check
	logic [7:0]  lk_a, lk_c, lk_len;
	logic [31:0] lk_b;
	logic [15:0] lk_a_sq, lk_c_sq;

	assign lk_a    = tracer_q[7:0];
	assign lk_len  = tracer_q[15:8];
	assign lk_c    = coupler_q;
	assign lk_b    = rt1_s[32].res[31:0];
	assign lk_a_sq = 16'(lk_a) * 16'(lk_a);
	assign lk_c_sq = 16'(lk_c) * 16'(lk_c);

	logic signed [16:0] t_ac_s1;
	logic [63:0] t_bb_s1;
	logic [40:0] t_den_s1, t_den_s2;
	logic signed [63:0] t_num_s2;
	keep_t t_k_s1, t_k_s2;
	keep_t t_k_d;

	always_comb begin
		t_k_d = rt1_k[32];
		if (rt1_k[32].status == ST_OK
			&& ((40'(lk_a) << WORK_BITS) + 40'(lk_b)) <= (40'(lk_c) << WORK_BITS)) begin
			t_k_d.status = ST_OPEN;
		end
	end

	always_ff @(posedge clk) begin
		t_ac_s1  <= signed'({1'b0, lk_a_sq}) - signed'({1'b0, lk_c_sq});
		t_bb_s1  <= 64'(lk_b) * 64'(lk_b);
		t_den_s1 <= (41'(lk_a) * 41'(lk_b)) << 1;
		t_k_s1   <= t_k_d;

		t_num_s2 <= (64'(t_ac_s1) <<< (2 * WORK_BITS)) + signed'(t_bb_s1);
		t_den_s2 <= t_den_s1;
		t_k_s2   <= t_k_s1;
	end

	// acos argument range check, divider set-up
	logic [63:0] t_anum;
	assign t_anum = (t_num_s2 < 0) ? unsigned'(-t_num_s2) : unsigned'(t_num_s2);

	dv_t   dv_s [0:21];
	keep_t dv_k [0:21];
	keep_t dv_k_d;

	always_comb begin
		dv_k_d = t_k_s2;
		if (t_k_s2.status == ST_OK
			&& (t_den_s2 == 41'd0 || t_anum > (64'(t_den_s2) << WORK_BITS))) begin
			dv_k_d.status = ST_RANGE;
		end
	end

	always_ff @(posedge clk) begin
		dv_s[0].rem  <= t_anum;
		dv_s[0].quot <= 21'd0;
		dv_s[0].den  <= t_den_s2;
		dv_s[0].neg  <= t_num_s2 < 0;
		dv_k[0]      <= dv_k_d;
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < 21; k++) begin : g_dv
		localparam int I = 20 - k;
		logic [63:0] dv_shift;
		dv_t dv_nxt;
		assign dv_shift = 64'(dv_s[k].den) << I;
		always_comb begin
			dv_nxt = dv_s[k];
			if (dv_s[k].rem >= dv_shift) begin
				dv_nxt.rem  = dv_s[k].rem - dv_shift;
				dv_nxt.quot = dv_s[k].quot | (21'd1 << I);
			end
		end
		always_ff @(posedge clk) begin
			dv_s[k+1] <= dv_nxt;
			dv_k[k+1] <= dv_k[k];
		end
	end

	// v = num / den toward zero, then 1 - v^2
	logic signed [21:0] vq;
	logic [43:0] v_vv_s1;
	keep_t v_k_s1;
	keep_t v_k_d;

	assign vq = dv_s[21].neg ? -22'(dv_s[21].quot) : 22'(dv_s[21].quot);

	always_comb begin
		v_k_d   = dv_k[21];
		v_k_d.v = vq;
	end

	always_ff @(posedge clk) begin
		v_vv_s1 <= unsigned'(44'(vq) * 44'(vq));
		v_k_s1  <= v_k_d;
	end

	// sr = floor(sqrt(2^40 - v^2))
	sq_t   rt2_s [0:21];
	keep_t rt2_k [0:21];

	always_ff @(posedge clk) begin
		rt2_s[0].n   <= 64'((44'd1 << (2 * WORK_BITS)) - v_vv_s1);
		rt2_s[0].res <= 64'd0;
		rt2_k[0]     <= v_k_s1;
	end

	for (genvar k = 0; k < 21; k++) begin : g_rt2
		always_ff @(posedge clk) begin
			rt2_s[k+1] <= sq_step(rt2_s[k], 20 - k);
			rt2_k[k+1] <= rt2_k[k];
		end
	end

	// alpha = atan2(sr, v)
	cord_t v2_s [0:N];
	keep_t v2_k [0:N];
	logic signed [39:0] v2_sr;
	assign v2_sr = 40'(rt2_s[21].res[20:0]);

	always_ff @(posedge clk) begin
		v2_k[0] <= rt2_k[21];
		if (rt2_k[21].v < 0) begin
			v2_s[0].x <= -40'(rt2_k[21].v);
			v2_s[0].y <= -v2_sr;
			v2_s[0].z <= (v2_sr >= 0) ? PI_Q30 : -PI_Q30;
		end else begin
			v2_s[0].x <= 40'(rt2_k[21].v);
			v2_s[0].y <= v2_sr;
			v2_s[0].z <= 36'sd0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_v2
		always_ff @(posedge clk) begin
			v2_s[k+1] <= vec_step(v2_s[k], k);
			v2_k[k+1] <= v2_k[k];
		end
	end

	// tracer direction alpha + phi
	logic signed [35:0] tr_th_s1;
	keep_t tr_k_s1;

	always_ff @(posedge clk) begin
		tr_th_s1 <= v2_s[N].z + v2_k[N].phi;
		tr_k_s1  <= v2_k[N];
	end

	cord_t tr_s [0:N];
	logic  tr_neg_s [0:N];
	keep_t tr_k [0:N];
	fold_t tr_f;

	assign tr_f = fold_angle(tr_th_s1);

	always_ff @(posedge clk) begin
		tr_s[0].x   <= GAIN_Q20;
		tr_s[0].y   <= 40'sd0;
		tr_s[0].z   <= tr_f.th;
		tr_neg_s[0] <= tr_f.neg;
		tr_k[0]     <= tr_k_s1;
	end

	for (genvar k = 0; k < N; k++) begin : g_tr
		always_ff @(posedge clk) begin
			tr_s[k+1]     <= rot_step(tr_s[k], k);
			tr_neg_s[k+1] <= tr_neg_s[k];
			tr_k[k+1]     <= tr_k[k];
		end
	end

	// tracer end in Q.20
	logic signed [23:0] tr_co, tr_si;
	logic signed [39:0] o_x_s1, o_y_s1;
	logic [1:0] o_st_s1;

	assign tr_co = tr_neg_s[N] ? 24'(-tr_s[N].x) : 24'(tr_s[N].x);
	assign tr_si = tr_neg_s[N] ? 24'(-tr_s[N].y) : 24'(tr_s[N].y);

	always_ff @(posedge clk) begin
		o_x_s1  <= 40'(tr_k[N].p1x) + 40'(signed'({1'b0, lk_len})) * 40'(tr_co);
		o_y_s1  <= 40'(tr_k[N].p1y) + 40'(signed'({1'b0, lk_len})) * 40'(tr_si);
		o_st_s1 <= tr_k[N].status;
	end

	// round half up to the output grid and saturate; zero when the status is not OK
	logic signed [39:0] o_rx, o_ry;
	assign o_rx = (o_x_s1 + (40'sd1 <<< (SH - 1))) >>> SH;
	assign o_ry = (o_y_s1 + (40'sd1 <<< (SH - 1))) >>> SH;

	always_ff @(posedge clk) begin
		status <= o_st_s1;
		if (o_st_s1 != ST_OK) begin
			end_x <= 20'sd0;
			end_y <= 20'sd0;
		end else begin
			end_x <= (o_rx > OUT_MAX) ? 20'(OUT_MAX) : (o_rx < OUT_MIN) ? 20'(OUT_MIN) : 20'(o_rx);
			end_y <= (o_ry > OUT_MAX) ? 20'(OUT_MAX) : (o_ry < OUT_MIN) ? 20'(OUT_MIN) : 20'(o_ry);
		end
	end

endmodule

/* verif/tb_two_crank_linkage_tracer_core.sv */
// ----------------------------------------------------------------------------
// tb_two_crank_linkage_tracer_core: self-checking bench for the linkage tracer
// Programs the linkage registers while the pipeline is empty, streams frame
// indexes with random gaps, and compares every tracer point and status with
// a fixed-point model of the linkage kept inside the bench.
// ----------------------------------------------------------------------------
module tb_two_crank_linkage_tracer_core import tclt_pkg::*; ();

	// expected tracer point of one frame
	typedef struct {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic [1:0] st;
	} tracer_pt_t;

	localparam longint ONE_Q20 = 64'sd1 << 20;
	localparam int IDLE_LIMIT = 4000;

	// linkage model plus queue of tracer points still to come
	class linkage_scoreboard;
		bit [16:0] regs[8];
		tracer_pt_t pending_pts[$];
		int errors;
		longint atan_tab[16] = '{843314856, 497837829, 263043836, 133525158,
			67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
			524287, 262143, 131071, 65535, 32767};
		bit [16:0] masks[8] = '{17'hFFFF, 17'hFFFF, 17'hFF, 17'hFF, 17'h1FFFF,
			17'h1FFFF, 17'hFF, 17'hFFFF};

		function void clear_regs();
			regs = '{17'd0, 17'd0, 17'd1, 17'd1, 17'd256, 17'd2, 17'd30, 17'd0};
		endfunction

		function void write_reg(logic [2:0] idx, logic [16:0] val);
			regs[idx] = val & masks[idx];
		endfunction

		function longint sx8(bit [16:0] v);
			return longint'($signed(v[7:0]));
		endfunction

		function longint root(longint n_in);
			longint unsigned n, res, b;
			n = n_in;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else res = res >> 1;
				b = b >> 2;
			end
			return longint'(res);
		endfunction

		// cosine/sine in Q.20 of a Q.30 angle
		function void rotate(longint th, output longint c, output longint s);
			longint x, y, nx;
			bit flip;
			x = GAIN_Q20;
			y = 0;
			flip = 0;
			if (th > PI_Q30) th -= TWO_PI_Q30;
			if (th < -PI_Q30) th += TWO_PI_Q30;
			if (th > HALF_PI_Q30) begin
				th -= PI_Q30;
				flip = 1;
			end else if (th < -HALF_PI_Q30) begin
				th += PI_Q30;
				flip = 1;
			end
			for (int k = 0; k < 16; k++) begin
				if (th >= 0) begin
					nx = x - (y >>> k);
					y = y + (x >>> k);
					th -= atan_tab[k];
				end else begin
					nx = x + (y >>> k);
					y = y - (x >>> k);
					th += atan_tab[k];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint bearing(longint y, longint x);
			longint z, nx;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? PI_Q30 : -PI_Q30;
				x = -x;
				y = -y;
			end
			for (int k = 0; k < 16; k++) begin
				if (y >= 0) begin
					nx = x + (y >>> k);
					y = y - (x >>> k);
					z += atan_tab[k];
				end else begin
					nx = x - (y >>> k);
					y = y + (x >>> k);
					z -= atan_tab[k];
				end
				x = nx;
			end
			return z;
		endfunction

		function void pin_at(int w, longint frame, output longint px, output longint py);
			longint spd, ini, r, p, deg, c, s;
			spd = sx8(regs[4 + w]);
			ini = longint'(regs[4 + w][16:8]);
			r = longint'(regs[2 + w][7:0]);
			p = frame * spd;
			deg = (spd < 0) ? ini - p : ini + p;
			deg = deg % 360;
			if (deg < 0) deg += 360;
			rotate(deg * DEG_Q30, c, s);
			px = sx8(regs[w]) * ONE_Q20 + r * c;
			py = sx8(regs[w] >> 8) * ONE_Q20 + r * s;
		endfunction

		function logic signed [19:0] to_grid(longint v);
			v = (v + 512) >>> 10;
			if (v > OUT_MAX) v = OUT_MAX;
			if (v < OUT_MIN) v = OUT_MIN;
			return v[19:0];
		endfunction

		// accepted frame: work out its tracer point
		function void note_frame(logic [15:0] fi);
			tracer_pt_t e;
			longint p1x, p1y, p2x, p2y, dx, dy, b, a, cl, len, num, den, anum, v, sr;
			longint th, co, si;
			pin_at(0, fi, p1x, p1y);
			pin_at(1, fi, p2x, p2y);
			dx = p2x - p1x;
			dy = p2y - p1y;
			a = longint'(regs[REG_TRACER][7:0]);
			len = longint'(regs[REG_TRACER][15:8]);
			cl = longint'(regs[REG_COUPLER][7:0]);
			e.x = '0;
			e.y = '0;
			e.st = ST_OK;
			if (dx == 0 && dy == 0) e.st = ST_COIN;
			else begin
				b = root(dx * dx + dy * dy);
				if (a * ONE_Q20 + b <= cl * ONE_Q20) e.st = ST_OPEN;
				else begin
					num = (a * a - cl * cl) * ONE_Q20 * ONE_Q20 + b * b;
					den = 2 * a * b;
					anum = num < 0 ? -num : num;
					if (den == 0 || anum > den * ONE_Q20) e.st = ST_RANGE;
					else begin
						v = num / den;
						sr = root(ONE_Q20 * ONE_Q20 - v * v);
						th = bearing(sr, v) + bearing(dy, dx);
						rotate(th, co, si);
						e.x = to_grid(p1x + len * co);
						e.y = to_grid(p1y + len * si);
					end
				end
			end
			pending_pts = {pending_pts, e};
		endfunction

		function void check_result(logic signed [19:0] x, logic signed [19:0] y,
			logic [1:0] st);
			tracer_pt_t e;
			if (pending_pts.size() == 0) begin
				$display("%0t: result with none expected: x=%0d y=%0d status=%0d",
					$time, x, y, st);
				errors++;
				return;
			end
			e = pending_pts.pop_front();
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (x !== e.x) begin
				$display("%0t: end_x expected %0d actual %0d", $time, e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$display("%0t: end_y expected %0d actual %0d", $time, e.y, y);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [16:0] cfg_wdata;
	logic start;
	logic busy;
	logic [15:0] frame_index;
	logic done;
	logic signed [19:0] end_x;
	logic signed [19:0] end_y;
	logic [1:0] status;

	linkage_scoreboard sb = new();
	int idle_cycles = 0;

	two_crank_linkage_tracer_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy),
		.frame_index(frame_index), .done(done), .end_x(end_x), .end_y(end_y),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (start && !busy) sb.note_frame(frame_index);
			if (done) sb.check_result(end_x, end_y, status);
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_two_crank_linkage_tracer_core: FAIL");
				$finish;
			end
		end
	end

	// one frame beat after a random gap
	task automatic send_frame(logic [15:0] f);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		frame_index <= f;
		do @(posedge clk); while (busy);
	endtask

	// drain the pipeline, then load all eight registers
	task automatic program_linkage(logic [16:0] v[8]);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_pts.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		for (int i = 0; i < 8; i++) begin
			cfg_index <= 3'(i);
			cfg_wdata <= v[i];
			sb.write_reg(3'(i), v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [16:0] xy(int x, int y);
		return {1'b0, 8'(y), 8'(x)};
	endfunction

	function automatic logic [16:0] motion(int spd, int ph);
		return {9'(ph), 8'(spd)};
	endfunction

	initial begin
		logic [16:0] v[8];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start = 1'b0;
		frame_index = '0;
		sb.clear_regs();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: both cranks on one pivot, triangle cannot close
		send_frame(16'd0);
		send_frame(16'hFFFF);

		// closing five-bar: frame extremes, all phases
		v = '{xy(-10, 0), xy(10, 0), 17'd5, 17'd5, motion(3, 0), motion(-7, 359),
			17'd20, {8'd15, 8'd20}};
		program_linkage(v);
		foreach (v[i]) send_frame(16'(i * 45));
		send_frame(16'h8000);
		send_frame(16'hFFFF);
		send_frame(16'h5555);
		send_frame(16'hAAAA);

		// pins coincide: identical cranks
		v = '{xy(4, -3), xy(4, -3), 17'd9, 17'd9, motion(5, 30), motion(5, 30),
			17'd10, {8'd10, 8'd20}};
		program_linkage(v);
		send_frame(16'd1);
		send_frame(16'd77);

		// arccos out of range, and zero radii with stationary cranks
		v = '{xy(0, 0), xy(20, 0), 17'd0, 17'd0, motion(0, 0), motion(0, 0),
			17'd10, {8'd9, 8'd200}};
		program_linkage(v);
		send_frame(16'd3);

		// extremes: far pivots, longest bars, fastest speeds, phase wrap, saturation
		v = '{xy(127, 127), xy(-128, -128), 17'd255, 17'd255, motion(127, 511),
			motion(-128, 511), 17'd255, {8'd255, 8'd255}};
		program_linkage(v);
		send_frame(16'd0);
		send_frame(16'hFFFF);
		v = '{xy(127, 127), xy(100, 127), 17'd40, 17'd40, motion(-1, 400),
			motion(1, 0), 17'd30, {8'd255, 8'd40}};
		program_linkage(v);
		send_frame(16'd0);
		send_frame(16'd123);
		send_frame(16'd999);

		// random linkages, mostly ones that close, some anywhere in range
		for (int ph = 0; ph < 26; ph++) begin
			if ($urandom_range(0, 4) == 0) begin
				foreach (v[i]) v[i] = 17'($urandom);
			end else begin
				v[REG_C1_CENTER] = xy($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
				v[REG_C2_CENTER] = xy($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
				v[REG_C1_RADIUS] = 17'($urandom_range(0, 15));
				v[REG_C2_RADIUS] = 17'($urandom_range(0, 15));
				v[REG_C1_MOTION] = motion($urandom_range(0, 255), $urandom_range(0, 511));
				v[REG_C2_MOTION] = motion($urandom_range(0, 255), $urandom_range(0, 511));
				v[REG_COUPLER] = 17'($urandom_range(5, 50));
				v[REG_TRACER] = {1'b0, 8'($urandom), 8'($urandom_range(5, 50))};
			end
			program_linkage(v);
			repeat (25) send_frame(16'($urandom));
		end

		// drain and finish
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_pts.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_two_crank_linkage_tracer_core: PASS");
		else
			$display("tb_two_crank_linkage_tracer_core: FAIL");
		$finish;
	end

endmodule
